// ===== rtl/mch_pkg.sv =====
package mch_pkg;

    localparam int CordicStages = 16;
    localparam int CordicW      = 36;
    localparam int ZW           = 28;

    localparam logic [2:0] RegBiasX     = 3'd0;
    localparam logic [2:0] RegBiasY     = 3'd1;
    localparam logic [2:0] RegBiasZ     = 3'd2;
    localparam logic [2:0] RegScaleX    = 3'd3;
    localparam logic [2:0] RegScaleY    = 3'd4;
    localparam logic [2:0] RegScaleZ    = 3'd5;
    localparam logic [2:0] RegFieldGain = 3'd6;
    localparam logic [2:0] RegTempGain  = 3'd7;

    localparam logic signed [ZW-1:0] TempOffsetQ16 = 28'sd2131886;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 28'sd2949120;
            5'd1:  v = 28'sd1740967;
            5'd2:  v = 28'sd919879;
            5'd3:  v = 28'sd466945;
            5'd4:  v = 28'sd234379;
            5'd5:  v = 28'sd117304;
            5'd6:  v = 28'sd58666;
            5'd7:  v = 28'sd29335;
            5'd8:  v = 28'sd14668;
            5'd9:  v = 28'sd7334;
            5'd10: v = 28'sd3667;
            5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;
            5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;
            5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;
            5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;
            5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;
            5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

    // Corrected-axis word travelling through the CORDIC.
    typedef struct packed {
        logic [23:0] field_x;
        logic [23:0] field_y;
        logic [23:0] field_z;
        logic [15:0] temperature;
        logic [1:0]  special;   // 0 none, 1 forced heading
        logic [8:0]  forced;
    } t_side;

endpackage

// ===== rtl/mch_cordic_stage.sv =====
module mch_cordic_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [4:0]                         i_idx,
    input  logic                               i_valid,
    input  logic signed [mch_pkg::CordicW-1:0] i_x,
    input  logic signed [mch_pkg::CordicW-1:0] i_y,
    input  logic signed [mch_pkg::ZW-1:0]      i_z,
    input  mch_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic signed [mch_pkg::CordicW-1:0] o_x,
    output logic signed [mch_pkg::CordicW-1:0] o_y,
    output logic signed [mch_pkg::ZW-1:0]      o_z,
    output mch_pkg::t_side                     o_side
);
    logic signed [mch_pkg::CordicW-1:0] w_xs, w_ys;

    assign w_xs = i_x >>> i_idx;
    assign w_ys = i_y >>> i_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side <= i_side;
            if (i_y > 0) begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + mch_pkg::atan_deg(i_idx);
            end else begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - mch_pkg::atan_deg(i_idx);
            end
        end
    end
endmodule

// ===== rtl/magnetometer_calibrate_heading.sv =====
// Magnetometer correction and heading pipeline.
// Input channel: one word per accepted handshake (i_valid high, o_stall low)
// carries the raw x, y, z counts and the raw temperature count.
// Output channel: one word per input word, on o_valid, taken when i_stall
// is low; it carries the three fields in Q8.16 gauss, the temperature in
// Q8.8 degrees and the heading in whole degrees, 1 to 360.
// The block takes one word every cycle while o_stall is low. It has 3 front
// stages (bias subtract and scale, gain multiply, rounding and saturation),
// one stage per CORDIC iteration (16) and one heading stage.
// The whole pipeline advances together; when the receiver stalls and the last
// stage holds a word, every stage freezes, so nothing is lost or repeated.
// Bubbles inside the pipeline stay where they are while the output is stalled,
// and o_stall follows that output stall within the same cycle.
// Synchronous reset clears all valid bits and loads the register defaults:
// zero biases, unit scales, field gain 1398 and temperature gain 655.
// The APB port writes registers at 4*index and reads them back; pready is
// always high. Configure only while the pipeline is empty.
module magnetometer_calibrate_heading (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_x,
    input  logic [15:0] i_raw_y,
    input  logic [15:0] i_raw_z,
    input  logic [15:0] i_raw_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_field_x,
    output logic [23:0] o_field_y,
    output logic [23:0] o_field_z,
    output logic [15:0] o_temperature,
    output logic [8:0]  o_heading_degrees,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N = mch_pkg::CordicStages;
    localparam int W = mch_pkg::CordicW;
    localparam int ZW = mch_pkg::ZW;

    logic [15:0] r_bias_x, r_bias_y, r_bias_z, r_scale_x, r_scale_y, r_scale_z;
    logic [23:0] r_field_gain;
    logic [15:0] r_temp_gain;
    logic [2:0]  w_ridx;
    logic        w_en;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= '0; r_bias_y <= '0; r_bias_z <= '0;
            r_scale_x <= 16'd4096; r_scale_y <= 16'd4096; r_scale_z <= 16'd4096;
            r_field_gain <= 24'd1398;
            r_temp_gain <= 16'd655;
        end else if (psel && penable && pwrite) begin
            unique case (w_ridx)
                mch_pkg::RegBiasX:     r_bias_x <= pwdata[15:0];
                mch_pkg::RegBiasY:     r_bias_y <= pwdata[15:0];
                mch_pkg::RegBiasZ:     r_bias_z <= pwdata[15:0];
                mch_pkg::RegScaleX:    r_scale_x <= pwdata[15:0];
                mch_pkg::RegScaleY:    r_scale_y <= pwdata[15:0];
                mch_pkg::RegScaleZ:    r_scale_z <= pwdata[15:0];
                mch_pkg::RegFieldGain: r_field_gain <= pwdata[23:0];
                mch_pkg::RegTempGain:  r_temp_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            mch_pkg::RegBiasX:     prdata = {16'd0, r_bias_x};
            mch_pkg::RegBiasY:     prdata = {16'd0, r_bias_y};
            mch_pkg::RegBiasZ:     prdata = {16'd0, r_bias_z};
            mch_pkg::RegScaleX:    prdata = {16'd0, r_scale_x};
            mch_pkg::RegScaleY:    prdata = {16'd0, r_scale_y};
            mch_pkg::RegScaleZ:    prdata = {16'd0, r_scale_z};
            mch_pkg::RegFieldGain: prdata = {8'd0, r_field_gain};
            mch_pkg::RegTempGain:  prdata = {16'd0, r_temp_gain};
            default:               prdata = '0;
        endcase
    end

    // Stage 1: c = (raw - bias) * scale, and raw temperature times gain.
    logic        r_v1;
    logic signed [34:0] r_cx, r_cy, r_cz;
    logic signed [33:0] r_t1;
    // Stage 2: field products and temperature offset.
    logic        r_v2;
    logic signed [34:0] r_cx2, r_cy2;
    logic signed [59:0] r_px, r_py, r_pz;
    logic signed [33:0] r_t2;
    // Stage 3: round, saturate, CORDIC pre-rotation.
    logic        r_v3;

    function automatic logic signed [34:0] corr(input logic [15:0] raw,
                                                input logic [15:0] bias,
                                                input logic [15:0] scale);
        logic signed [16:0] d;
        d = 17'($signed(raw)) - 17'($signed(bias));
        return 35'(d * $signed({1'b0, scale}));
    endfunction

    function automatic logic [23:0] fsat(input logic signed [59:0] p);
        logic signed [59:0] r;
        r = (p + 60'sd524288) >>> 20;
        if (r > 60'sd8388607) return 24'h7FFFFF;
        if (r < -60'sd8388608) return 24'h800000;
        return r[23:0];
    endfunction

    logic signed [W-1:0]  w_x0, w_y0;
    logic signed [ZW-1:0] w_z0;
    mch_pkg::t_side       w_side0;
    logic signed [33:0]   w_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
        end
        if (w_en) begin
            r_cx <= corr(i_raw_x, r_bias_x, r_scale_x);
            r_cy <= corr(i_raw_y, r_bias_y, r_scale_y);
            r_cz <= corr(i_raw_z, r_bias_z, r_scale_z);
            r_t1 <= 34'($signed(i_raw_temperature) * $signed({1'b0, r_temp_gain}));
            r_cx2 <= r_cx; r_cy2 <= r_cy;
            r_px <= 60'(r_cx * $signed({1'b0, r_field_gain}));
            r_py <= 60'(r_cy * $signed({1'b0, r_field_gain}));
            r_pz <= 60'(r_cz * $signed({1'b0, r_field_gain}));
            r_t2 <= r_t1 + 34'(mch_pkg::TempOffsetQ16) + 34'sd128;
        end
    end

    always_comb begin
        w_tr = r_t2 >>> 8;
        w_side0.field_x = fsat(r_px);
        w_side0.field_y = fsat(r_py);
        w_side0.field_z = fsat(r_pz);
        if (w_tr > 34'sd32767)       w_side0.temperature = 16'h7FFF;
        else if (w_tr < -34'sd32768) w_side0.temperature = 16'h8000;
        else                         w_side0.temperature = w_tr[15:0];
        w_side0.special = 2'd0;
        w_side0.forced = 9'd0;
        if (r_cy2 == 0) begin
            w_side0.special = 2'd1;
            w_side0.forced = (r_cx2 < 0) ? 9'd180 : 9'd360;
        end else if (r_cx2 == 0) begin
            w_side0.special = 2'd1;
            w_side0.forced = (r_cy2 > 0) ? 9'd90 : 9'd270;
        end
        if (r_cx2 < 0) begin
            w_x0 = -W'(r_cx2);
            w_y0 = -W'(r_cy2);
            w_z0 = (r_cy2 >= 0) ? 28'sd11796480 : -28'sd11796480;
        end else begin
            w_x0 = W'(r_cx2);
            w_y0 = W'(r_cy2);
            w_z0 = '0;
        end
    end

    logic signed [W-1:0]  r_x0, r_y0;
    logic signed [ZW-1:0] r_z0;
    mch_pkg::t_side       r_side0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= w_x0; r_y0 <= w_y0; r_z0 <= w_z0; r_side0 <= w_side0;
        end
    end

    logic                 w_v [N+1];
    logic signed [W-1:0]  w_x [N+1];
    logic signed [W-1:0]  w_y [N+1];
    logic signed [ZW-1:0] w_z [N+1];
    mch_pkg::t_side       w_s [N+1];

    assign w_v[0] = r_v3;
    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;
    assign w_s[0] = r_side0;

    for (genvar g = 0; g < N; g++) begin : g_cordic
        mch_cordic_stage u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_idx(5'(g)),
            .i_valid(w_v[g]), .i_x(w_x[g]), .i_y(w_y[g]), .i_z(w_z[g]),
            .i_side(w_s[g]),
            .o_valid(w_v[g+1]), .o_x(w_x[g+1]), .o_y(w_y[g+1]), .o_z(w_z[g+1]),
            .o_side(w_s[g+1])
        );
    end

    // Heading: truncate toward zero, then fold into 1..360.
    logic signed [ZW-1:0] w_zf;
    logic signed [11:0]   w_deg;
    logic [8:0]           w_head;

    always_comb begin
        w_zf = w_z[N];
        if (w_zf >= 0) w_deg = 12'(w_zf >>> 16);
        else           w_deg = -12'((-w_zf) >>> 16);
        if (w_deg <= 0) w_deg = w_deg + 12'sd360;
        if (w_deg > 12'sd360) w_deg = w_deg - 12'sd360;
        if (w_deg < 12'sd1) w_deg = 12'sd1;
        w_head = (w_s[N].special != 2'd0) ? w_s[N].forced : w_deg[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_v[N];
        end
        if (w_en) begin
            o_field_x <= w_s[N].field_x;
            o_field_y <= w_s[N].field_y;
            o_field_z <= w_s[N].field_z;
            o_temperature <= w_s[N].temperature;
            o_heading_degrees <= w_head;
        end
    end
endmodule
